// File: hw/rtl/huffman_code_bit_packer_assert.svh
// Assertion macros used by the bit packer top level.
`ifndef HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define HCBP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define HCBP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: hw/rtl/hcbp_pkg.sv
// Types and constants shared by the bit packer modules.
`default_nettype none

package hcbp_pkg;

  localparam int unsigned BYTE_W = 8;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  localparam logic [3:0] FULL_BYTE_BITS = 4'd8;
  localparam logic [3:0] NO_BITS        = 4'd0;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  symbol;
    logic [31:0] code_value;
    logic [5:0]  code_length;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] valid_bits;
    logic       is_tail;
    logic       bad_symbol;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic       load;
    logic       is_tail;
    logic       bad;
    logic [2:0] count;
    logic [2:0] tail_bits;
  } emit_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/hcbp_code_mem.sv
// Code table memory with one write port and one registered read port.
`default_nettype none

module hcbp_code_mem #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned DATA_W = 38
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DATA_W-1:0]        wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/hcbp_emitter.sv
// Output stage that shifts packed bytes out one word at a time.
`default_nettype none

module hcbp_emitter #(
  parameter int unsigned ACC_W = 40
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire hcbp_pkg::emit_ctrl_t ctrl_i,
  input  wire logic [ACC_W-1:0]     stream_i,
  output logic                      busy_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output hcbp_pkg::out_word_t       out_data_o
);

  logic [2:0]       cnt_q;
  logic [ACC_W-1:0] stream_q;
  logic             tail_q;
  logic             bad_q;
  logic [2:0]       tail_bits_q;
  logic             out_acc;

  assign out_acc     = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != 3'd0);
  assign busy_o      = out_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else if (ctrl_i.load) begin
      cnt_q <= ctrl_i.count;
    end else if (out_acc) begin
      cnt_q <= cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      stream_q    <= stream_i;
      tail_q      <= ctrl_i.is_tail;
      bad_q       <= ctrl_i.bad;
      tail_bits_q <= ctrl_i.tail_bits;
    end else if (out_acc) begin
      stream_q <= stream_q << hcbp_pkg::BYTE_W;
    end
  end

  always_comb begin
    out_data_o.out_byte   = stream_q[ACC_W-1 -: hcbp_pkg::BYTE_W];
    out_data_o.is_tail    = tail_q;
    out_data_o.bad_symbol = bad_q;
    out_data_o.last       = (cnt_q == 3'd1);
    if (tail_q) begin
      out_data_o.valid_bits = {1'b0, tail_bits_q};
    end else if (bad_q) begin
      out_data_o.valid_bits = hcbp_pkg::NO_BITS;
    end else begin
      out_data_o.valid_bits = hcbp_pkg::FULL_BYTE_BITS;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/huffman_code_bit_packer.sv
// Top level of the MSB-first Huffman code bit packer.
//
//   Channel | Direction | Handshake              | Word
//   in      | input     | in_valid_i/in_ready_o   | hcbp_pkg::in_word_t
//   out     | output    | out_valid_o/out_ready_i | hcbp_pkg::out_word_t
//
// A load writes the code table when it is accepted; an ignored opcode is
// dropped. An encode reads the table, packs in ST_LOOKUP and hands whole
// bytes to the byte-serial output stage, as does a bad symbol or a flush
// with a single word. Reset clears the loaded flags and the partial byte at
// once; the code table itself needs no clearing. A stalled output holds the
// block until the final word of the item leaves.
`default_nettype none

module huffman_code_bit_packer #(
  parameter int unsigned MAX_CODE_BITS = 32,
  parameter int unsigned SYMBOL_COUNT  = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire hcbp_pkg::in_word_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output hcbp_pkg::out_word_t      out_data_o
);

  `include "huffman_code_bit_packer_assert.svh"

  localparam int unsigned LEN_W = $clog2(MAX_CODE_BITS + 1);
  localparam int unsigned ENT_W = MAX_CODE_BITS + LEN_W;
  localparam int unsigned ACC_W = MAX_CODE_BITS + hcbp_pkg::BYTE_W;
  localparam int unsigned SH_W  = $clog2(ACC_W + 1);
  localparam int unsigned IDX_W = $clog2(SYMBOL_COUNT);

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e                  state_q, state_d;
  logic [7:0]              partial_q, partial_d;
  logic [2:0]              fill_q, fill_d;
  logic [SYMBOL_COUNT-1:0] loaded_q, loaded_d;

  logic                    emit_busy;
  hcbp_pkg::emit_ctrl_t    emit_ctrl;
  logic [ACC_W-1:0]        emit_stream;

  logic                    in_acc;
  logic [IDX_W-1:0]        sym_idx;
  logic                    in_range;
  logic                    hit;
  logic                    mem_we;
  logic                    mem_re;
  logic [LEN_W-1:0]        len_sat;
  logic [ENT_W-1:0]        mem_wdata;
  logic [ENT_W-1:0]        mem_rdata;

  logic [MAX_CODE_BITS-1:0] rd_code;
  logic [LEN_W-1:0]         rd_len;
  logic [SH_W-1:0]          total;
  logic [SH_W-1:0]          shift;
  logic [2:0]               nbytes;
  logic [ACC_W-1:0]         code_mask;
  logic [ACC_W-1:0]         packed_bits;
  logic [ACC_W-1:0]         rest_bits;

  assign in_ready_o = (state_q == ST_IDLE) && !emit_busy;
  assign in_acc     = in_valid_i && in_ready_o;
  assign sym_idx    = in_data_i.symbol[IDX_W-1:0];
  assign in_range   = ({1'b0, in_data_i.symbol} < 9'(SYMBOL_COUNT));
  assign hit        = in_range && loaded_q[sym_idx];

  assign len_sat = (in_data_i.code_length > 6'(MAX_CODE_BITS)) ?
                   LEN_W'(MAX_CODE_BITS) : LEN_W'(in_data_i.code_length);
  assign mem_wdata = {len_sat, in_data_i.code_value[MAX_CODE_BITS-1:0]};
  assign mem_we    = in_acc && (in_data_i.opcode == hcbp_pkg::OP_LOAD) && in_range;
  assign mem_re    = in_acc && (in_data_i.opcode == hcbp_pkg::OP_ENCODE) && hit;

  hcbp_code_mem #(
    .DEPTH  (SYMBOL_COUNT),
    .DATA_W (ENT_W)
  ) u_code_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (sym_idx),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (sym_idx),
    .rdata_o (mem_rdata)
  );

  assign rd_code     = mem_rdata[MAX_CODE_BITS-1:0];
  assign rd_len      = mem_rdata[ENT_W-1 -: LEN_W];
  assign total       = SH_W'(fill_q) + SH_W'(rd_len);
  assign shift       = SH_W'(ACC_W) - total;
  assign nbytes      = 3'(total >> 3);
  assign code_mask   = ~({ACC_W{1'b1}} << rd_len);
  assign packed_bits = {partial_q, {(ACC_W - hcbp_pkg::BYTE_W){1'b0}}} |
                       ((ACC_W'(rd_code) & code_mask) << shift);
  assign rest_bits   = packed_bits << {nbytes, 3'b000};

  always_comb begin
    state_d     = state_q;
    partial_d   = partial_q;
    fill_d      = fill_q;
    loaded_d    = loaded_q;
    emit_ctrl   = '0;
    emit_stream = '0;
    if (mem_we) begin
      loaded_d[sym_idx] = 1'b1;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_data_i.opcode)
            hcbp_pkg::OP_ENCODE: begin
              if (hit) begin
                state_d = ST_LOOKUP;
              end else begin
                emit_ctrl.load  = 1'b1;
                emit_ctrl.bad   = 1'b1;
                emit_ctrl.count = 3'd1;
              end
            end
            hcbp_pkg::OP_FLUSH: begin
              emit_ctrl.load      = 1'b1;
              emit_ctrl.is_tail   = 1'b1;
              emit_ctrl.count     = 3'd1;
              emit_ctrl.tail_bits = fill_q;
              emit_stream = {partial_q, {(ACC_W - hcbp_pkg::BYTE_W){1'b0}}};
              partial_d   = 8'd0;
              fill_d      = 3'd0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOOKUP: begin
        state_d         = ST_IDLE;
        partial_d       = rest_bits[ACC_W-1 -: hcbp_pkg::BYTE_W];
        fill_d          = total[2:0];
        emit_ctrl.load  = (nbytes != 3'd0);
        emit_ctrl.count = nbytes;
        emit_stream     = packed_bits;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      partial_q <= 8'd0;
      fill_q    <= 3'd0;
      loaded_q  <= '0;
    end else begin
      state_q   <= state_d;
      partial_q <= partial_d;
      fill_q    <= fill_d;
      loaded_q  <= loaded_d;
    end
  end

  hcbp_emitter #(
    .ACC_W (ACC_W)
  ) u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (emit_ctrl),
    .stream_i    (emit_stream),
    .busy_o      (emit_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `HCBP_ASSERT(a_lookup_one_cycle, state_q == ST_LOOKUP |=> state_q == ST_IDLE, "lookup did not end")
  `HCBP_ASSERT(a_emit_when_idle, emit_ctrl.load |-> !emit_busy, "emitter loaded while busy")
  `HCBP_ASSERT(a_hit_to_lookup, mem_re |=> state_q == ST_LOOKUP, "table read without lookup")
  `HCBP_ASSERT(a_one_item, out_valid_o |-> !in_ready_o, "input taken while a word waits")
  `HCBP_ASSERT(a_flush_clears, in_acc && in_data_i.opcode == hcbp_pkg::OP_FLUSH |=> fill_q == 3'd0, "flush left bits")

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking testbench for the MSB-first Huffman code bit packer.
module testbench;

  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam logic [5:0] MAX_CODE_LEN = 6'd32;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 24;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  hcbp_pkg::in_word_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  hcbp_pkg::out_word_t out_data_o;

  logic [31:0] code_bits [256];
  logic [5:0] code_len [256];
  logic loaded [256];
  logic [7:0] acc_byte;
  int unsigned acc_bits;
  hcbp_pkg::out_word_t expected_words [$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned rx_hold_request = 0;
  int unsigned rx_hold_left = 0;

  huffman_code_bit_packer DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // The receiver stalls at random, or for a whole stretch when one is requested.
  always @(negedge clk_i) begin
    if (rx_hold_request != 0) begin
      rx_hold_left = rx_hold_request;
      rx_hold_request = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    hcbp_pkg::out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        error_count++;
        $display("%0t: unexpected word, expected none, actual %h", $time, out_data_o);
      end else begin
        want = expected_words.pop_front();
        check_field("out_byte", want.out_byte, out_data_o.out_byte);
        check_field("valid_bits", 8'(want.valid_bits), 8'(out_data_o.valid_bits));
        check_field("is_tail", 8'(want.is_tail), 8'(out_data_o.is_tail));
        check_field("bad_symbol", 8'(want.bad_symbol), 8'(out_data_o.bad_symbol));
        check_field("last", 8'(want.last), 8'(out_data_o.last));
      end
    end
  end

  function automatic void clear_packer_state();
    for (int s = 0; s < 256; s++) begin
      loaded[s] = 1'b0;
      code_bits[s] = '0;
      code_len[s] = '0;
    end
    acc_byte = '0;
    acc_bits = 0;
  endfunction

  function automatic void predict_packed_words(hcbp_pkg::in_word_t w);
    int i;
    int unsigned emitted;
    hcbp_pkg::out_word_t res;
    emitted = 0;
    case (w.opcode)
      hcbp_pkg::OP_LOAD: begin
        code_bits[w.symbol] = w.code_value;
        code_len[w.symbol] = (w.code_length > MAX_CODE_LEN) ? MAX_CODE_LEN : w.code_length;
        loaded[w.symbol] = 1'b1;
      end
      hcbp_pkg::OP_ENCODE: begin
        if (!loaded[w.symbol]) begin
          res = '{8'h00, hcbp_pkg::NO_BITS, 1'b0, 1'b1, 1'b1};
          expected_words.push_back(res);
        end else begin
          for (i = int'(code_len[w.symbol]); i > 0; i--) begin
            if (code_bits[w.symbol][i - 1]) acc_byte[7 - acc_bits] = 1'b1;
            acc_bits++;
            if (acc_bits == 8) begin
              res = '{acc_byte, hcbp_pkg::FULL_BYTE_BITS, 1'b0, 1'b0, 1'b0};
              expected_words.push_back(res);
              emitted++;
              acc_byte = '0;
              acc_bits = 0;
            end
          end
          if (emitted != 0) begin
            res = expected_words.pop_back();
            res.last = 1'b1;
            expected_words.push_back(res);
          end
        end
      end
      hcbp_pkg::OP_FLUSH: begin
        res = '{acc_byte, 4'(acc_bits), 1'b1, 1'b0, 1'b1};
        expected_words.push_back(res);
        acc_byte = '0;
        acc_bits = 0;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic hcbp_pkg::in_word_t make_word(logic [1:0] op, logic [7:0] sym,
                                                   logic [31:0] value, logic [5:0] len);
    hcbp_pkg::in_word_t w;
    w.opcode = op;
    w.symbol = sym;
    w.code_value = value;
    w.code_length = len;
    return w;
  endfunction

  function automatic logic [5:0] random_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return 6'd0;
    if (r < 75) return 6'($urandom_range(12, 1));
    if (r < 92) return 6'($urandom_range(32, 13));
    return 6'($urandom_range(63, 33));
  endfunction

  task automatic send_word(hcbp_pkg::in_word_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_packed_words(w);
    @(negedge clk_i);
  endtask

  task automatic test_directed_codes();
    send_word(make_word(hcbp_pkg::OP_LOAD, 8'd0, 32'h0000_0000, 6'd0));
    send_word(make_word(hcbp_pkg::OP_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32));
    send_word(make_word(hcbp_pkg::OP_LOAD, 8'd1, 32'h0000_00A5, 6'd8));
    send_word(make_word(hcbp_pkg::OP_LOAD, 8'd2, 32'h0000_0005, 6'd3));
    send_word(make_word(hcbp_pkg::OP_LOAD, 8'd3, 32'h1234_5678, 6'd63));
    send_word(make_word(hcbp_pkg::OP_LOAD, 8'd4, 32'hFFFF_FFFF, 6'd1));
    send_word(make_word(hcbp_pkg::OP_ENCODE, 8'd255, 32'h0, 6'd0));
    send_word(make_word(hcbp_pkg::OP_ENCODE, 8'd2, 32'hFFFF_FFFF, 6'd63));
    send_word(make_word(hcbp_pkg::OP_ENCODE, 8'd255, 32'h0, 6'd0));
    send_word(make_word(hcbp_pkg::OP_FLUSH, 8'd0, 32'h0, 6'd0));
    send_word(make_word(hcbp_pkg::OP_FLUSH, 8'd255, 32'hFFFF_FFFF, 6'd63));
    send_word(make_word(hcbp_pkg::OP_ENCODE, 8'd0, 32'h0, 6'd0));
    send_word(make_word(hcbp_pkg::OP_ENCODE, 8'd77, 32'h0, 6'd0));
    send_word(make_word(OP_IGNORED, 8'd255, 32'hFFFF_FFFF, 6'd63));
    send_word(make_word(hcbp_pkg::OP_ENCODE, 8'd3, 32'h0, 6'd0));
    send_word(make_word(hcbp_pkg::OP_ENCODE, 8'd4, 32'h0, 6'd0));
    send_word(make_word(hcbp_pkg::OP_ENCODE, 8'd1, 32'h0, 6'd0));
    send_word(make_word(hcbp_pkg::OP_LOAD, 8'd2, 32'h0000_0002, 6'd2));
    send_word(make_word(hcbp_pkg::OP_ENCODE, 8'd2, 32'h0, 6'd0));
    send_word(make_word(hcbp_pkg::OP_ENCODE, 8'd0, 32'h0, 6'd0));
    send_word(make_word(hcbp_pkg::OP_FLUSH, 8'd0, 32'h0, 6'd0));
  endtask

  task automatic test_random_stream(int unsigned count);
    int unsigned pick;
    logic [7:0] sym;
    repeat (count) begin
      pick = $urandom_range(99);
      sym = 8'($urandom_range(255));
      if (pick < 15) begin
        send_word(make_word(hcbp_pkg::OP_LOAD, sym, $urandom, random_length()));
      end else if (pick < 88) begin
        if (pick < 80) begin
          repeat (16) if (!loaded[sym]) sym = 8'($urandom_range(255));
        end
        send_word(make_word(hcbp_pkg::OP_ENCODE, sym, $urandom, 6'($urandom_range(63))));
      end else if (pick < 97) begin
        send_word(make_word(hcbp_pkg::OP_FLUSH, sym, $urandom, 6'($urandom_range(63))));
      end else begin
        send_word(make_word(OP_IGNORED, sym, $urandom, 6'($urandom_range(63))));
      end
    end
  endtask

  task automatic test_output_hold();
    send_word(make_word(hcbp_pkg::OP_LOAD, 8'd255, $urandom, 6'd32));
    rx_hold_request = 300;
    repeat (30) begin
      send_word(make_word(hcbp_pkg::OP_ENCODE, 8'd255, $urandom, 6'($urandom_range(63))));
    end
    send_word(make_word(hcbp_pkg::OP_FLUSH, 8'd0, 32'h0, 6'd0));
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    clear_packer_state();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    tx_idle_pct = 18;
    rx_idle_pct = 72;
    test_directed_codes();
    test_random_stream(200);

    tx_idle_pct = 72;
    rx_idle_pct = 18;
    test_random_stream(200);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_stream(100);
    test_output_hold();

    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
